// File: hdl/rtc_calendar_counter_macros.svh
// Assertion macros for the calendar counter.
`ifndef RTC_CALENDAR_COUNTER_MACROS_SVH
`define RTC_CALENDAR_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

`define RTCC_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("rtcc assertion failed");

`define RTCC_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("rtcc assertion failed");

`else

`define RTCC_ASSERT_IMP(lbl, clk, rst_n, pre, post)

`define RTCC_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// File: hdl/rtcc_pkg.sv
// Types, constants and calendar functions of the calendar counter.
package rtcc_pkg;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_LOAD    = 2'd1;
	localparam logic [1:0] FUNC_CONVERT = 2'd2;

	localparam logic [5:0] SEC_MAX   = 6'd59;
	localparam logic [5:0] MIN_MAX   = 6'd59;
	localparam logic [4:0] HOUR_MAX  = 5'd23;
	localparam logic [6:0] YEAR_MAX  = 7'd99;
	localparam logic [5:0] DAY_HOURS = 6'd24;
	localparam logic [3:0] MONTH_MAX = 4'd12;
	localparam logic signed [5:0] OFFSET_MAX = 6'sd23;
	localparam logic signed [5:0] OFFSET_MIN = -6'sd23;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hr;
		logic [4:0] day;
		logic [3:0] mon;
		logic [6:0] yr;
	} caltime_t;

	typedef struct packed {
		caltime_t tm;
		logic     minute_tick;
		logic     time_valid;
	} result_t;

	localparam caltime_t RESET_TIME = '{sec: 6'd0, min: 6'd0, hr: 5'd0,
		day: 5'd1, mon: 4'd1, yr: 7'd16};
	localparam caltime_t ZERO_TIME = '{sec: 6'd0, min: 6'd0, hr: 5'd0,
		day: 5'd0, mon: 4'd0, yr: 7'd0};

	function automatic logic [4:0] days_of(logic [3:0] mon, logic [6:0] yr);
		logic [4:0] d;
		unique case (mon)
			4'd2: d = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	function automatic logic check_time(caltime_t t);
		logic ok;
		ok = 1'b1;
		if (t.hr > HOUR_MAX || t.min > MIN_MAX || t.sec > SEC_MAX)
			ok = 1'b0;
		if (t.mon == 4'd0 || t.mon > MONTH_MAX || t.yr > YEAR_MAX)
			ok = 1'b0;
		if (t.day == 5'd0 || t.day > days_of(t.mon, t.yr))
			ok = 1'b0;
		return ok;
	endfunction

	function automatic caltime_t day_up(caltime_t t);
		caltime_t r;
		r = t;
		if (({1'b0, t.day} + 6'd1) > {1'b0, days_of(t.mon, t.yr)}) begin
			r.day = 5'd1;
			if (t.mon >= MONTH_MAX) begin
				r.mon = 4'd1;
				r.yr  = (t.yr >= YEAR_MAX) ? 7'd0 : t.yr + 7'd1;
			end else begin
				r.mon = t.mon + 4'd1;
			end
		end else begin
			r.day = t.day + 5'd1;
		end
		return r;
	endfunction

	function automatic caltime_t day_down(caltime_t t);
		caltime_t r;
		r = t;
		if (t.day > 5'd1) begin
			r.day = t.day - 5'd1;
		end else if (!(t.yr == 7'd0 && t.mon <= 4'd1)) begin
			if (t.mon <= 4'd1) begin
				r.mon = MONTH_MAX;
				r.yr  = t.yr - 7'd1;
			end else begin
				r.mon = t.mon - 4'd1;
			end
			r.day = days_of(r.mon, r.yr);
		end
		return r;
	endfunction

endpackage

// File: hdl/rtcc_calc.sv
// Combinational tick, load check and hour conversion for one word.
module rtcc_calc (
	input  logic [1:0]        func,
	input  rtcc_pkg::caltime_t sup,
	input  logic signed [5:0] hour_offset,
	input  rtcc_pkg::caltime_t held,
	output rtcc_pkg::result_t  res,
	output rtcc_pkg::caltime_t held_nxt
);

	rtcc_pkg::caltime_t tick_t;
	logic               tick_roll;
	logic               sup_ok;
	logic signed [5:0]  off;
	logic [5:0]         neg_off;
	logic [5:0]         hr_sum;
	rtcc_pkg::caltime_t conv_t;

	always_comb begin
		tick_t    = held;
		tick_roll = 1'b0;
		if (held.sec >= rtcc_pkg::SEC_MAX) begin
			tick_t.sec = 6'd0;
			tick_roll  = 1'b1;
			if (held.min >= rtcc_pkg::MIN_MAX) begin
				tick_t.min = 6'd0;
				if (held.hr >= rtcc_pkg::HOUR_MAX) begin
					tick_t.hr = 5'd0;
					tick_t    = rtcc_pkg::day_up(tick_t);
				end else begin
					tick_t.hr = held.hr + 5'd1;
				end
			end else begin
				tick_t.min = held.min + 6'd1;
			end
		end else begin
			tick_t.sec = held.sec + 6'd1;
		end
	end

	assign sup_ok = rtcc_pkg::check_time(sup);

	always_comb begin
		if (hour_offset > rtcc_pkg::OFFSET_MAX)
			off = rtcc_pkg::OFFSET_MAX;
		else if (hour_offset < rtcc_pkg::OFFSET_MIN)
			off = rtcc_pkg::OFFSET_MIN;
		else
			off = hour_offset;
		neg_off = -off;
		conv_t  = sup;
		hr_sum  = {1'b0, sup.hr};
		if (off > 6'sd0) begin
			hr_sum = {1'b0, sup.hr} + off;
			if (hr_sum > {1'b0, rtcc_pkg::HOUR_MAX}) begin
				hr_sum = hr_sum - rtcc_pkg::DAY_HOURS;
				conv_t = rtcc_pkg::day_up(sup);
			end
		end else if (off < 6'sd0) begin
			if ({1'b0, sup.hr} < neg_off) begin
				hr_sum = {1'b0, sup.hr} + rtcc_pkg::DAY_HOURS;
				conv_t = rtcc_pkg::day_down(sup);
			end
			hr_sum = hr_sum - neg_off;
		end
		conv_t.hr = hr_sum[4:0];
	end

	always_comb begin
		held_nxt = held;
		res      = '{tm: held, minute_tick: 1'b0, time_valid: 1'b0};
		unique case (func)
			rtcc_pkg::FUNC_TICK: begin
				held_nxt = tick_t;
				res      = '{tm: tick_t, minute_tick: tick_roll, time_valid: 1'b1};
			end
			rtcc_pkg::FUNC_LOAD: begin
				if (sup_ok)
					held_nxt = sup;
				res = '{tm: (sup_ok ? sup : held), minute_tick: 1'b0,
					time_valid: sup_ok};
			end
			rtcc_pkg::FUNC_CONVERT: begin
				res = '{tm: (sup_ok ? conv_t : rtcc_pkg::ZERO_TIME),
					minute_tick: 1'b0, time_valid: sup_ok};
			end
			default: begin
				res = '{tm: held, minute_tick: 1'b0, time_valid: 1'b0};
			end
		endcase
	end

endmodule

// File: hdl/rtc_calendar_counter.sv
// Calendar clock top level: input register, calendar logic, result register.
// One result word comes out for every input word, through the input register
// and then the result register; a new word can be taken every cycle, so
// sustained rate is one word per cycle while out_ready stays high. The
// calendar logic between the two registers is combinational, and in_ready
// follows out_ready combinationally when both stages are full.
// Func 0 ticks the held time one second, 1 loads a checked time, 2 converts
// a supplied time by hour_offset without touching the held time; func 3
// returns the held time with time_valid low. After reset the held time is
// 00:00:00 on 1 January of year 16.
`include "rtc_calendar_counter_macros.svh"

module rtc_calendar_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [5:0]        in_seconds,
	input  logic [5:0]        in_minutes,
	input  logic [4:0]        in_hours,
	input  logic [4:0]        in_day,
	input  logic [3:0]        in_month,
	input  logic [6:0]        in_year,
	input  logic signed [5:0] hour_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        out_seconds,
	output logic [5:0]        out_minutes,
	output logic [4:0]        out_hours,
	output logic [4:0]        out_day,
	output logic [3:0]        out_month,
	output logic [6:0]        out_year,
	output logic              minute_tick,
	output logic              time_valid
);

	logic               valid_s1;
	logic [1:0]         func_s1;
	rtcc_pkg::caltime_t sup_s1;
	logic signed [5:0]  offset_s1;
	logic               valid_s2;
	rtcc_pkg::result_t  res_s2;
	rtcc_pkg::caltime_t held_q;
	rtcc_pkg::result_t  res_c;
	rtcc_pkg::caltime_t held_nxt;
	logic               adv_s1;
	logic               adv_s2;
	logic               in_take;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1   <= func;
			sup_s1    <= '{sec: in_seconds, min: in_minutes, hr: in_hours,
				day: in_day, mon: in_month, yr: in_year};
			offset_s1 <= hour_offset;
		end
	end

	rtcc_calc u_calc (
		.func        (func_s1),
		.sup         (sup_s1),
		.hour_offset (offset_s1),
		.held        (held_q),
		.res         (res_c),
		.held_nxt    (held_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			held_q   <= rtcc_pkg::RESET_TIME;
		end else begin
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_s1)
				held_q <= held_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_c;
	end

	assign out_valid   = valid_s2;
	assign out_seconds = res_s2.tm.sec;
	assign out_minutes = res_s2.tm.min;
	assign out_hours   = res_s2.tm.hr;
	assign out_day     = res_s2.tm.day;
	assign out_month   = res_s2.tm.mon;
	assign out_year    = res_s2.tm.yr;
	assign minute_tick = res_s2.minute_tick;
	assign time_valid  = res_s2.time_valid;

	`RTCC_ASSERT_IMP(a_held_ok, clk, arst_n, 1'b1, rtcc_pkg::check_time(held_q))
	`RTCC_ASSERT_IMP(a_out_ok, clk, arst_n, valid_s2 && res_s2.time_valid, rtcc_pkg::check_time(res_s2.tm))
	`RTCC_ASSERT_IMP(a_tick_sec, clk, arst_n, valid_s2 && res_s2.minute_tick, res_s2.tm.sec == 6'd0 && res_s2.time_valid)
	`RTCC_ASSERT_NXT(a_held_hold, clk, arst_n, !adv_s1, $stable(held_q))

endmodule

// File: dv/rtc_calendar_counter_test.sv
// Self-checking testbench for the calendar counter: ticks, loads and hour conversions.
module rtc_calendar_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_IDLE = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		logic [1:0]        func;
		logic [5:0]        sec;
		logic [5:0]        min;
		logic [4:0]        hr;
		logic [4:0]        day;
		logic [3:0]        mon;
		logic [6:0]        yr;
		logic signed [5:0] off;
	} word_t;

	typedef struct {
		int sec, min, hr, day, mon, yr;
	} stamp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        func = '0;
	logic [5:0]        in_seconds = '0;
	logic [5:0]        in_minutes = '0;
	logic [4:0]        in_hours = '0;
	logic [4:0]        in_day = '0;
	logic [3:0]        in_month = '0;
	logic [6:0]        in_year = '0;
	logic signed [5:0] hour_offset = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [5:0]        out_seconds;
	logic [5:0]        out_minutes;
	logic [4:0]        out_hours;
	logic [4:0]        out_day;
	logic [3:0]        out_month;
	logic [6:0]        out_year;
	logic              minute_tick;
	logic              time_valid;

	word_t             pending_words [$];
	rtcc_pkg::result_t due_results [$];
	stamp_t  held = '{sec: 0, min: 0, hr: 0, day: 1, mon: 1, yr: 16};
	string   field_names [8] = '{"seconds", "minutes", "hours", "day", "month", "year",
		"minute_tick", "time_valid"};

	int   words_queued = 0;
	int   words_in = 0;
	int   errors = 0;
	int   stalled_cycles = 0;
	int   send_gap = 0;
	int   take_gap = 0;
	logic in_taken = 1'b0;
	logic quiet = 1'b0;
	logic idle_on;

	assign idle_on = !quiet && ((words_in / 150) % 3 != 2);

	rtc_calendar_counter DUT (.*);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int month_days(int mon, int yr);
		if (mon < 1 || mon > 12)
			return 31;
		if (mon == 2 && yr % 4 == 0)
			return 29;
		return MONTH_LEN[mon - 1];
	endfunction

	function automatic bit stamp_ok(stamp_t t);
		if (t.hr > 23 || t.min > 59 || t.sec > 59)
			return 1'b0;
		if (t.mon == 0 || t.mon > 12 || t.yr > 99)
			return 1'b0;
		return t.day != 0 && t.day <= month_days(t.mon, t.yr);
	endfunction

	function automatic stamp_t next_day(stamp_t t);
		t.day++;
		if (t.day > month_days(t.mon, t.yr)) begin
			t.day = 1;
			t.mon++;
			if (t.mon > 12) begin
				t.mon = 1;
				t.yr = (t.yr >= 99) ? 0 : t.yr + 1;
			end
		end
		return t;
	endfunction

	function automatic stamp_t prev_day(stamp_t t);
		if (t.day > 1) begin
			t.day--;
		end else if (!(t.yr == 0 && t.mon <= 1)) begin
			if (t.mon <= 1) begin
				t.mon = 12;
				t.yr--;
			end else begin
				t.mon--;
			end
			t.day = month_days(t.mon, t.yr);
		end
		return t;
	endfunction

	function automatic rtcc_pkg::result_t calendar_step(word_t w);
		stamp_t            s;
		stamp_t            r;
		rtcc_pkg::result_t res;
		int                shift;
		bit                tick;
		bit                ok;
		s = '{sec: w.sec, min: w.min, hr: w.hr, day: w.day, mon: w.mon, yr: w.yr};
		tick = 1'b0;
		ok = 1'b1;
		r = held;
		case (w.func)
			rtcc_pkg::FUNC_TICK: begin
				held.sec++;
				if (held.sec > 59) begin
					tick = 1'b1;
					held.sec = 0;
					held.min++;
					if (held.min > 59) begin
						held.min = 0;
						held.hr++;
						if (held.hr > 23) begin
							held.hr = 0;
							held = next_day(held);
						end
					end
				end
				r = held;
			end
			rtcc_pkg::FUNC_LOAD: begin
				ok = stamp_ok(s);
				if (ok)
					held = s;
				r = held;
			end
			rtcc_pkg::FUNC_CONVERT: begin
				shift = w.off;
				if (shift > 23)
					shift = 23;
				if (shift < -23)
					shift = -23;
				ok = stamp_ok(s);
				if (!ok) begin
					r = '{default: 0};
				end else begin
					if (shift > 0) begin
						s.hr += shift;
						if (s.hr > 23) begin
							s.hr -= 24;
							s = next_day(s);
						end
					end else if (shift < 0) begin
						if (s.hr < -shift) begin
							s.hr += 24;
							s = prev_day(s);
						end
						s.hr += shift;
					end
					r = s;
				end
			end
			default: ok = 1'b0;
		endcase
		res.tm.sec = r.sec[5:0];
		res.tm.min = r.min[5:0];
		res.tm.hr = r.hr[4:0];
		res.tm.day = r.day[4:0];
		res.tm.mon = r.mon[3:0];
		res.tm.yr = r.yr[6:0];
		res.minute_tick = tick;
		res.time_valid = ok;
		return res;
	endfunction

	function automatic word_t make_word(logic [1:0] f, int s, int m, int h, int d, int mo,
		int y, int off);
		word_t w;
		w.func = f;
		w.sec = s[5:0];
		w.min = m[5:0];
		w.hr = h[4:0];
		w.day = d[4:0];
		w.mon = mo[3:0];
		w.yr = y[6:0];
		w.off = off[5:0];
		return w;
	endfunction

	function automatic word_t noise_word(logic [1:0] f);
		return make_word(f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endfunction

	function automatic word_t rand_time(logic [1:0] f, bit near_edge);
		int y, mo, d, h, m, s, off;
		y = (near_edge && $urandom_range(0, 1)) ? ($urandom_range(0, 1) ? 99 : 0)
			: $urandom_range(0, 99);
		if (near_edge && $urandom_range(0, 1))
			case ($urandom_range(0, 2))
				0: mo = 1;
				1: mo = 2;
				default: mo = 12;
			endcase
		else
			mo = $urandom_range(1, 12);
		if (near_edge && $urandom_range(0, 1))
			d = $urandom_range(0, 1) ? month_days(mo, y) : 1;
		else
			d = $urandom_range(1, month_days(mo, y));
		h = (near_edge && $urandom_range(0, 1)) ? ($urandom_range(0, 1) ? 23 : 0)
			: $urandom_range(0, 23);
		m = (near_edge && $urandom_range(0, 1)) ? 59 : $urandom_range(0, 59);
		s = (near_edge && $urandom_range(0, 1)) ? $urandom_range(50, 59)
			: $urandom_range(0, 59);
		off = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 46) - 23;
		return make_word(f, s, m, h, d, mo, y, off);
	endfunction

	task automatic push_word(word_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic add_random_words(int upto);
		int r;
		while (words_queued < upto) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				push_word(rand_time(rtcc_pkg::FUNC_LOAD, 1'b1));
				repeat ($urandom_range(1, 12))
					push_word(noise_word(rtcc_pkg::FUNC_TICK));
			end else if (r < 45) begin
				push_word(noise_word(rtcc_pkg::FUNC_TICK));
			end else if (r < 80) begin
				push_word(rand_time(rtcc_pkg::FUNC_CONVERT, r < 65));
			end else if (r < 88) begin
				push_word(rand_time(rtcc_pkg::FUNC_LOAD, 1'b0));
			end else begin
				push_word(noise_word(2'($urandom_range(0, 3))));
			end
		end
	endtask

	task automatic wait_drained();
		while (words_in != words_queued || due_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 11);
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				func <= w.func;
				in_seconds <= w.sec;
				in_minutes <= w.min;
				in_hours <= w.hr;
				in_day <= w.day;
				in_month <= w.mon;
				in_year <= w.yr;
				hour_offset <= w.off;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (take_gap > 0) begin
			take_gap--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			take_gap = $urandom_range(0, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rtcc_pkg::result_t want;
		logic [6:0]        got_f [8];
		logic [6:0]        want_f [8];
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_results.push_back(calendar_step(make_word(func, in_seconds, in_minutes,
					in_hours, in_day, in_month, in_year, hour_offset)));
				words_in++;
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("word with nothing due, seconds", 32'(out_seconds), 0);
				end else begin
					want = due_results.pop_front();
					got_f = '{7'(out_seconds), 7'(out_minutes), 7'(out_hours), 7'(out_day),
						7'(out_month), out_year, 7'(minute_tick), 7'(time_valid)};
					want_f = '{7'(want.tm.sec), 7'(want.tm.min), 7'(want.tm.hr),
						7'(want.tm.day), 7'(want.tm.mon), want.tm.yr,
						7'(want.minute_tick), 7'(want.time_valid)};
					for (int i = 0; i < 8; i++)
						if (got_f[i] !== want_f[i])
							report_mismatch(field_names[i], 32'(got_f[i]), 32'(want_f[i]));
				end
			end
			in_taken <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stalled_cycles = 0;
			end else begin
				stalled_cycles++;
				if (stalled_cycles >= STALL_LIMIT) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_word(noise_word(rtcc_pkg::FUNC_TICK));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 59, 59, 23, 31, 12, 99, 0));
		push_word(noise_word(rtcc_pkg::FUNC_TICK));
		push_word(noise_word(rtcc_pkg::FUNC_TICK));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 58, 59, 23, 29, 2, 0, 0));
		push_word(noise_word(rtcc_pkg::FUNC_TICK));
		push_word(noise_word(rtcc_pkg::FUNC_TICK));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 0, 0, 29, 2, 1, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 0, 24, 1, 1, 5, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 60, 0, 0, 1, 1, 5, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 63, 0, 1, 1, 5, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 0, 0, 1, 0, 5, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 0, 0, 1, 13, 5, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0));
		push_word(make_word(rtcc_pkg::FUNC_LOAD, 0, 0, 0, 1, 1, 100, 0));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 59, 59, 23, 31, 12, 99, 23));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 0, 0, 0, 1, 1, 0, -23));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 12, 34, 5, 1, 3, 1, -7));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 0, 0, 22, 28, 2, 4, 31));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 0, 0, 3, 1, 1, 50, -32));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 63, 63, 31, 31, 15, 127, -1));
		push_word(make_word(rtcc_pkg::FUNC_CONVERT, 30, 30, 12, 15, 6, 20, 0));
		push_word(make_word(FUNC_IDLE, 63, 63, 31, 31, 15, 127, -1));
		push_word(make_word(FUNC_IDLE, 0, 0, 0, 0, 0, 0, 0));
		wait_drained();

		add_random_words(1400);
		wait_drained();

		quiet = 1'b1;
		add_random_words(1775);
		wait_drained();
		repeat (8) @(posedge clk);

		if (due_results.size() != 0)
			report_mismatch("results never seen", due_results.size(), 0);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
